[sv/tbtl_pkg.sv]
// Package for the token bucket table limiter: sizes, payload structs,
// command and status codes, and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package tbtl_pkg;

    localparam int BUCKETS    = 16;
    localparam int TOKEN_BITS = 16;
    localparam int ADDR_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int FIELD_W    = 16;
    localparam int SLOT_W     = 4;
    localparam int SUM_W      = ((TOKEN_BITS > FIELD_W) ? TOKEN_BITS : FIELD_W) + 1;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [TOKEN_BITS-1:0] t_tok;
    typedef logic [SUM_W-1:0]      t_sum;

    localparam t_tok TOK_MAX = '1;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_OPEN   = 3'd1,
        KIND_FETCH  = 3'd2,
        KIND_RETURN = 3'd3,
        KIND_CLOSE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_INVALID     = 2'd1,
        STAT_NO_SPACE    = 2'd2,
        STAT_WOULD_BLOCK = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_TICK,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic [SLOT_W-1:0]  bucket;
        logic [FIELD_W-1:0] amount;
        logic [FIELD_W-1:0] rate;
        logic [FIELD_W-1:0] cap;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] granted;
    } t_res;

    typedef struct packed {
        t_tok tokens;
        t_tok rate;
        t_tok cap;
    } t_entry;

    // Clamp a field value to the largest token count.
    function automatic t_tok sat_tok(logic [FIELD_W-1:0] v);
        if (t_sum'(v) > t_sum'(TOK_MAX)) begin
            return TOK_MAX;
        end
        return t_tok'(v);
    endfunction

endpackage

[sv/tbtl_cmd_if.sv]
// Command channel of the token bucket table limiter: valid, ready and one
// command payload. Depends on tbtl_pkg.
`timescale 1ns / 1ps

interface tbtl_cmd_if import tbtl_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/tbtl_res_if.sv]
// Result channel of the token bucket table limiter: valid, ready and one
// result payload. Depends on tbtl_pkg.
`timescale 1ns / 1ps

interface tbtl_res_if import tbtl_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/token_bucket_table_limiter.sv]
// Token bucket table: BUCKETS buckets, each with tokens, refill rate and cap held
// in one synchronous memory (one write port and one registered read port) and an
// in-use flag per slot in flip-flops that reset clears. One command is worked at
// a time. Open, close and any rejected command finish in the idle state; fetch and
// return read the memory, then modify and write back in the read-modify-write state;
// tick walks the table one entry per cycle through the memory, reading the
// next entry while writing back the current one. Each command gives exactly one
// result transaction, held in an output register; while that register is still
// full, a finished result waits one stage back and the next command is not taken.
// Depends on tbtl_pkg, tbtl_cmd_if and tbtl_res_if.
`timescale 1ns / 1ps

module token_bucket_table_limiter import tbtl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbtl_cmd_if.sink    i_cmd,
    tbtl_res_if.source  o_res
);

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    t_addr               r_idx, n_idx;
    logic [BUCKETS-1:0]  r_use, n_use;
    t_res                r_out, r_hold;
    logic                r_out_valid;
    t_entry              r_mem [BUCKETS];
    t_entry              r_rd;

    logic   mem_we, mem_re;
    t_addr  mem_wa, mem_ra;
    t_entry mem_wd;

    logic   res_done;
    t_res   res;
    logic   out_free;

    logic   free_found;
    t_addr  free_idx;
    t_addr  cmd_addr;
    logic   in_range;
    t_addr  rmw_addr;

    t_sum   sum_ret, sum_tick;
    t_tok   ret_after, ret_added, fetch_grant, tick_tokens;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign cmd_addr = t_addr'(i_cmd.data.bucket);
    assign in_range = (int'(i_cmd.data.bucket) < BUCKETS);
    assign rmw_addr = t_addr'(r_cmd.bucket);

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = BUCKETS - 1; k >= 0; k--) begin
            if (!r_use[k]) begin
                free_found = 1'b1;
                free_idx   = t_addr'(k);
            end
        end
    end

    // datapath on the entry read back from memory
    always_comb begin
        sum_ret     = t_sum'(r_rd.tokens) + t_sum'(r_cmd.amount);
        ret_after   = (sum_ret > t_sum'(r_rd.cap)) ? r_rd.cap : t_tok'(sum_ret);
        ret_added   = (ret_after > r_rd.tokens) ? (ret_after - r_rd.tokens) : '0;
        fetch_grant = (t_sum'(r_rd.tokens) < t_sum'(r_cmd.amount))
                      ? r_rd.tokens : t_tok'(r_cmd.amount);
        sum_tick    = t_sum'(r_rd.tokens) + t_sum'(r_rd.rate);
        tick_tokens = (sum_tick > t_sum'(r_rd.cap)) ? r_rd.cap : t_tok'(sum_tick);
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_use    = r_use;
        mem_we   = 1'b0;
        mem_wa   = rmw_addr;
        mem_wd   = r_rd;
        mem_re   = 1'b0;
        mem_ra   = rmw_addr;
        res_done = 1'b0;
        res      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.data;
                    unique case (i_cmd.data.kind)
                        KIND_TICK: begin
                            mem_re  = 1'b1;
                            mem_ra  = '0;
                            n_idx   = '0;
                            n_state = ST_TICK;
                        end
                        KIND_OPEN: begin
                            res_done = 1'b1;
                            if (free_found) begin
                                n_use[free_idx] = 1'b1;
                                mem_we          = 1'b1;
                                mem_wa          = free_idx;
                                mem_wd.tokens   = '0;
                                mem_wd.rate     = sat_tok(i_cmd.data.rate);
                                mem_wd.cap      = sat_tok(i_cmd.data.cap);
                                res.status      = STAT_OK;
                                res.slot        = SLOT_W'(free_idx);
                            end else begin
                                res.status = STAT_NO_SPACE;
                            end
                        end
                        KIND_FETCH, KIND_RETURN: begin
                            if (!in_range || i_cmd.data.amount == '0 || !r_use[cmd_addr]) begin
                                res_done   = 1'b1;
                                res.status = STAT_INVALID;
                            end else begin
                                mem_re  = 1'b1;
                                mem_ra  = cmd_addr;
                                n_state = ST_RMW;
                            end
                        end
                        KIND_CLOSE: begin
                            res_done = 1'b1;
                            if (in_range) begin
                                n_use[cmd_addr] = 1'b0;
                                res.status      = STAT_OK;
                            end else begin
                                res.status = STAT_INVALID;
                            end
                        end
                        default: begin
                            res_done   = 1'b1;
                            res.status = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                res_done = 1'b1;
                if (r_cmd.kind == KIND_FETCH) begin
                    if (r_rd.tokens == '0) begin
                        res.status = STAT_WOULD_BLOCK;
                    end else begin
                        mem_we        = 1'b1;
                        mem_wd.tokens = r_rd.tokens - fetch_grant;
                        res.status    = STAT_OK;
                        res.granted   = FIELD_W'(fetch_grant);
                    end
                end else begin
                    mem_we        = 1'b1;
                    mem_wd.tokens = ret_after;
                    res.status    = STAT_OK;
                    res.granted   = FIELD_W'(ret_added);
                end
            end
            ST_TICK: begin
                // write back the entry read last cycle if its slot is in use, fetch the next one
                mem_we        = r_use[r_idx];
                mem_wa        = r_idx;
                mem_wd.tokens = tick_tokens;
                mem_re        = 1'b1;
                mem_ra        = r_idx + 1'b1;
                n_idx         = r_idx + 1'b1;
                if (r_idx == t_addr'(BUCKETS - 1)) begin
                    res_done   = 1'b1;
                    res.status = STAT_OK;
                end
            end
            ST_HOLD: begin
                res_done = 1'b1;
                res      = r_hold;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (res_done) begin
            n_state = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_use <= n_use;
            if (res_done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        if (res_done && out_free) begin
            r_out <= res;
        end
        if (res_done && !out_free) begin
            r_hold <= res;
        end
    end

    // bucket table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

endmodule
